[rtl/tau_pkg.sv]
// ----------------------------------------------------------------------------
// Time-stamp arithmetic unit package
// Shared widths, operation codes and the constants of the seconds plus
// nanoseconds arithmetic.
// ----------------------------------------------------------------------------
package tau_pkg;

  localparam int unsigned TS_W   = 32;
  localparam int unsigned OP_W   = 3;
  // Quotient of a 32-bit count by 1000 needs 23 bits, a remainder below 1e6 20.
  localparam int unsigned QUOT_W = 23;
  localparam int unsigned REM_W  = 20;

  localparam logic [TS_W-1:0] INVALID_MARK     = 32'hFFFF_FFFF;
  localparam logic [TS_W-1:0] SEC_LIMIT_RESET  = 32'hFFFF_FFFE;
  localparam logic [TS_W-1:0] NSEC_LIMIT       = 32'd999_999_999;
  localparam logic [TS_W-1:0] NSEC_PER_SEC     = 32'd1_000_000_000;
  localparam logic [TS_W-1:0] USEC_PER_SEC     = 32'd1_000_000;
  localparam logic [TS_W-1:0] MSEC_PER_SEC     = 32'd1_000;

  // floor(2^32 / divisor): the estimated quotient is low by at most one.
  localparam logic [QUOT_W-1:0] RECIP_US = 23'd4_294;
  localparam logic [QUOT_W-1:0] RECIP_MS = 23'd4_294_967;

  // Scale of the remainder back into nanoseconds.
  localparam logic [REM_W-1:0] US_TO_NS = 20'd1_000;
  localparam logic [REM_W-1:0] MS_TO_NS = 20'd1_000_000;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 3'd0,
    OP_SUB     = 3'd1,
    OP_CMP     = 3'd2,
    OP_FROM_US = 3'd3,
    OP_FROM_MS = 3'd4,
    OP_SET     = 3'd5,
    OP_CHECK   = 3'd6
  } op_t;

endpackage

[rtl/tau_channels.sv]
// ----------------------------------------------------------------------------
// Time-stamp arithmetic unit channels
// Valid/ready request channels for operands and for results.
// ----------------------------------------------------------------------------
interface tau_in_if import tau_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  logic [TS_W-1:0] a_seconds;
  logic [TS_W-1:0] a_nanoseconds;
  logic [TS_W-1:0] b_seconds;
  logic [TS_W-1:0] b_nanoseconds;
  logic [TS_W-1:0] tick_count;

  modport source (
    output valid, operation, a_seconds, a_nanoseconds, b_seconds, b_nanoseconds,
           tick_count,
    input  ready
  );
  modport sink (
    input  valid, operation, a_seconds, a_nanoseconds, b_seconds, b_nanoseconds,
           tick_count,
    output ready
  );
endinterface

interface tau_out_if import tau_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [TS_W-1:0] result_seconds;
  logic [TS_W-1:0] result_nanoseconds;
  logic            is_less;
  logic            is_equal;
  logic            in_range;

  modport source (
    output valid, result_seconds, result_nanoseconds, is_less, is_equal, in_range,
    input  ready
  );
  modport sink (
    input  valid, result_seconds, result_nanoseconds, is_less, is_equal, in_range,
    output ready
  );
endinterface

[rtl/timestamp_arithmetic_unit_top.sv]
// ----------------------------------------------------------------------------
// Time-stamp arithmetic unit
// Seconds plus nanoseconds ALU: add, subtract, compare, tick conversion,
// clamped set and validity check, pipelined over five register stages.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per handshake: an operation, time-stamps a and b
//   and a tick count. out_ch returns exactly one result per request, in order.
//   cfg_we/cfg_wdata write the largest valid seconds value; write it only while
//   no request is in flight.
// Pipeline:
//   A taken request passes the stage 1 to 4 registers and the output register;
//   one request is taken every cycle unless the output stalls. The depth is set
//   by the tick conversion: reciprocal multiply, back-multiply and subtract,
//   quotient correction, nanosecond scaling multiply, and the limit check.
// Reset:
//   rst_n clears all stage valid bits and loads the seconds limit with
//   4294967294.
// Stalls:
//   While the output holds a result that is not taken, the whole pipeline
//   freezes and in_ch.ready is low; nothing is dropped or repeated. Empty
//   stages are not filled during a stall; a request enters only as it moves.
// ----------------------------------------------------------------------------
module timestamp_arithmetic_unit_top import tau_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  tau_in_if.sink          in_ch,
  tau_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [TS_W-1:0] cfg_wdata
);

  typedef struct packed {
    op_t               op;
    logic [TS_W-1:0]   a_s;
    logic [TS_W-1:0]   a_ns;
    logic [TS_W-1:0]   b_s;
    logic [TS_W-1:0]   b_ns;
    logic [TS_W-1:0]   tick;
    logic [TS_W-1:0]   nsum;
    logic [TS_W:0]     ssum;
    logic              less;
    logic              eq;
    logic              ns_lt;
    logic [QUOT_W-1:0] q_est;
  } s1_t;

  typedef struct packed {
    op_t               op;
    logic [TS_W:0]     sec;
    logic [TS_W-1:0]   ns;
    logic              less;
    logic              eq;
    logic [QUOT_W-1:0] q_est;
    logic [REM_W:0]    r_est;
  } s2_t;

  typedef struct packed {
    op_t               op;
    logic [TS_W-1:0]   sec;
    logic [TS_W-1:0]   ns;
    logic              less;
    logic              eq;
    logic [QUOT_W-1:0] quot;
    logic [REM_W-1:0]  rem;
  } s3_t;

  typedef struct packed {
    op_t             op;
    logic [TS_W-1:0] sec;
    logic [TS_W-1:0] ns;
    logic            less;
    logic            eq;
  } s4_t;

  typedef struct packed {
    logic [TS_W-1:0] sec;
    logic [TS_W-1:0] ns;
    logic            less;
    logic            eq;
    logic            rng;
  } res_t;

  logic [TS_W-1:0] sec_limit_r;
  logic            adv;
  logic            v1_r, v2_r, v3_r, v4_r, vo_r;
  s1_t             s1_r, s1_nxt;
  s2_t             s2_r, s2_nxt;
  s3_t             s3_r, s3_nxt;
  s4_t             s4_r, s4_nxt;
  res_t            out_r, out_nxt;

  // Stage 1 helpers.
  op_t                      in_op;
  logic [QUOT_W-1:0]        recip;
  logic [TS_W+QUOT_W-1:0]   recip_prod;
  // Stage 2 helpers.
  logic                     carry;
  logic [TS_W-1:0]          divisor;
  logic [TS_W-1:0]          back_prod;
  logic [TS_W-1:0]          r_diff;
  // Stage 3 helpers.
  logic [REM_W:0]           divisor_n;
  logic                     r_over;
  logic [REM_W:0]           r_fix;
  // Stage 4 helpers.
  logic [REM_W-1:0]         scale;
  logic [2*REM_W-1:0]       scaled;

  // The whole pipeline moves whenever the output register is free or emptying.
  assign adv         = !vo_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_limit_r <= SEC_LIMIT_RESET;
    end else if (cfg_we) begin
      sec_limit_r <= cfg_wdata;
    end
  end

  // Stage 1: operand sums, ordering and the reciprocal quotient estimate.
  always_comb begin
    in_op             = op_t'(in_ch.operation);
    recip             = (in_op == OP_FROM_US) ? RECIP_US : RECIP_MS;
    recip_prod        = (TS_W+QUOT_W)'(in_ch.tick_count) * (TS_W+QUOT_W)'(recip);
    s1_nxt.op         = in_op;
    s1_nxt.a_s        = in_ch.a_seconds;
    s1_nxt.a_ns       = in_ch.a_nanoseconds;
    s1_nxt.b_s        = in_ch.b_seconds;
    s1_nxt.b_ns       = in_ch.b_nanoseconds;
    s1_nxt.tick       = in_ch.tick_count;
    s1_nxt.nsum       = in_ch.a_nanoseconds + in_ch.b_nanoseconds;
    s1_nxt.ssum       = {1'b0, in_ch.a_seconds} + {1'b0, in_ch.b_seconds};
    s1_nxt.ns_lt      = in_ch.a_nanoseconds < in_ch.b_nanoseconds;
    s1_nxt.less       = (in_ch.a_seconds < in_ch.b_seconds) ||
                        ((in_ch.a_seconds == in_ch.b_seconds) &&
                         (in_ch.a_nanoseconds < in_ch.b_nanoseconds));
    s1_nxt.eq         = (in_ch.a_seconds == in_ch.b_seconds) &&
                        (in_ch.a_nanoseconds == in_ch.b_nanoseconds);
    s1_nxt.q_est      = recip_prod[TS_W+QUOT_W-1:TS_W];
  end

  // Stage 2: carry or borrow, clamping, and the first remainder estimate.
  always_comb begin
    carry        = s1_r.nsum > NSEC_LIMIT;
    divisor      = (s1_r.op == OP_FROM_US) ? USEC_PER_SEC : MSEC_PER_SEC;
    back_prod    = {{(TS_W-QUOT_W){1'b0}}, s1_r.q_est} * divisor;
    r_diff       = s1_r.tick - back_prod;
    s2_nxt.op    = s1_r.op;
    s2_nxt.less  = (s1_r.op == OP_CMP) && s1_r.less;
    s2_nxt.eq    = (s1_r.op == OP_CMP) && s1_r.eq;
    s2_nxt.q_est = s1_r.q_est;
    s2_nxt.r_est = r_diff[REM_W:0];
    s2_nxt.sec   = '0;
    s2_nxt.ns    = '0;
    case (s1_r.op)
      OP_ADD: begin
        s2_nxt.sec = s1_r.ssum + {{TS_W{1'b0}}, carry};
        s2_nxt.ns  = carry ? (s1_r.nsum - NSEC_PER_SEC) : s1_r.nsum;
      end
      OP_SUB: begin
        if (s1_r.less) begin
          s2_nxt.sec = {1'b0, INVALID_MARK};
          s2_nxt.ns  = INVALID_MARK;
        end else if (s1_r.ns_lt) begin
          s2_nxt.sec = {1'b0, s1_r.a_s - s1_r.b_s - 32'd1};
          s2_nxt.ns  = s1_r.a_ns + NSEC_PER_SEC - s1_r.b_ns;
        end else begin
          s2_nxt.sec = {1'b0, s1_r.a_s - s1_r.b_s};
          s2_nxt.ns  = s1_r.a_ns - s1_r.b_ns;
        end
      end
      OP_SET: begin
        s2_nxt.sec = {1'b0, (s1_r.a_s > sec_limit_r) ? sec_limit_r : s1_r.a_s};
        s2_nxt.ns  = (s1_r.a_ns > NSEC_LIMIT) ? NSEC_LIMIT : s1_r.a_ns;
      end
      OP_CHECK: begin
        s2_nxt.sec = {1'b0, s1_r.a_s};
        s2_nxt.ns  = s1_r.a_ns;
      end
      default: begin
        s2_nxt.sec = '0;
        s2_nxt.ns  = '0;
      end
    endcase
  end

  // Stage 3: seconds overflow and nanosecond clamp on add, and the quotient correction.
  always_comb begin
    divisor_n   = (s2_r.op == OP_FROM_US) ? USEC_PER_SEC[REM_W:0] : MSEC_PER_SEC[REM_W:0];
    r_over      = s2_r.r_est >= divisor_n;
    r_fix       = r_over ? (s2_r.r_est - divisor_n) : s2_r.r_est;
    s3_nxt.op   = s2_r.op;
    s3_nxt.less = s2_r.less;
    s3_nxt.eq   = s2_r.eq;
    s3_nxt.quot = r_over ? (s2_r.q_est + {{(QUOT_W-1){1'b0}}, 1'b1}) : s2_r.q_est;
    s3_nxt.rem  = r_fix[REM_W-1:0];
    s3_nxt.sec  = s2_r.sec[TS_W-1:0];
    s3_nxt.ns   = s2_r.ns;
    if (s2_r.op == OP_ADD) begin
      if (s2_r.sec > {1'b0, sec_limit_r}) begin
        s3_nxt.sec = INVALID_MARK;
        s3_nxt.ns  = INVALID_MARK;
      end else if (s2_r.ns > NSEC_LIMIT) begin
        s3_nxt.ns  = NSEC_LIMIT;
      end
    end
  end

  // Stage 4: remainder scaled back into nanoseconds for tick conversion.
  always_comb begin
    scale       = (s3_r.op == OP_FROM_US) ? US_TO_NS : MS_TO_NS;
    scaled      = (2*REM_W)'(s3_r.rem) * (2*REM_W)'(scale);
    s4_nxt.op   = s3_r.op;
    s4_nxt.less = s3_r.less;
    s4_nxt.eq   = s3_r.eq;
    s4_nxt.sec  = s3_r.sec;
    s4_nxt.ns   = s3_r.ns;
    if ((s3_r.op == OP_FROM_US) || (s3_r.op == OP_FROM_MS)) begin
      s4_nxt.sec = {{(TS_W-QUOT_W){1'b0}}, s3_r.quot};
      s4_nxt.ns  = scaled[TS_W-1:0];
    end
  end

  // Output stage: limit check. Compare and the unused code report no range.
  always_comb begin
    out_nxt.sec  = s4_r.sec;
    out_nxt.ns   = s4_r.ns;
    out_nxt.less = s4_r.less;
    out_nxt.eq   = s4_r.eq;
    case (s4_r.op)
      OP_ADD, OP_SUB, OP_FROM_US, OP_FROM_MS, OP_SET, OP_CHECK: begin
        out_nxt.rng = (s4_r.sec <= sec_limit_r) && (s4_r.ns <= NSEC_LIMIT);
      end
      default: begin
        out_nxt.rng = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      vo_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      s4_r  <= s4_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid              = vo_r;
  assign out_ch.result_seconds     = out_r.sec;
  assign out_ch.result_nanoseconds = out_r.ns;
  assign out_ch.is_less            = out_r.less;
  assign out_ch.is_equal           = out_r.eq;
  assign out_ch.in_range           = out_r.rng;

`ifndef SYNTHESIS
  // A request in the last stage reaches the output when the pipeline moves.
  a_last_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v4_r) |=> vo_r)
    else $error("request lost between last stage and output");

  // A held output freezes every stage valid bit.
  a_stall_holds_stages: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(v1_r) && $stable(v2_r) && $stable(v3_r) && $stable(v4_r)))
    else $error("pipeline moved during an output stall");

  // Compare flags and the range flag never come from the same operation.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && (out_r.less || out_r.eq)) |-> (!out_r.rng && out_r.sec == '0))
    else $error("compare flags set on a non-compare result");

  // An add that overflows the seconds limit marks both result parts invalid.
  a_invalid_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && s3_r.op == OP_ADD && s3_r.sec == INVALID_MARK) |-> s3_r.ns == INVALID_MARK
      || s3_r.sec <= sec_limit_r)
    else $error("add overflow marked in one part only");
`endif

endmodule

[test/tau_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Time-stamp arithmetic unit result checker
// Watches the request and result channels and the seconds limit port. It
// works out the result of every accepted request and compares each returned
// result, field by field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module tau_result_checker import tau_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  tau_in_if               in_mon,
  tau_out_if              out_mon,
  input  logic            cfg_we,
  input  logic [TS_W-1:0] cfg_wdata,
  output int unsigned     results_owed,
  output int unsigned     mismatch_count
);

  typedef struct packed {
    logic [TS_W-1:0] seconds;
    logic [TS_W-1:0] nanoseconds;
    logic            is_less;
    logic            is_equal;
    logic            in_range;
  } ts_result_t;

  logic [TS_W-1:0] seconds_limit;
  ts_result_t      pending_results[$];

  function automatic ts_result_t timestamp_op_result(
    input logic [OP_W-1:0] op,
    input logic [TS_W-1:0] as,
    input logic [TS_W-1:0] ans,
    input logic [TS_W-1:0] bs,
    input logic [TS_W-1:0] bns,
    input logic [TS_W-1:0] tk,
    input logic [TS_W-1:0] lim
  );
    ts_result_t      r;
    logic [TS_W-1:0] nsum;
    logic [TS_W+1:0] ssum;
    logic            earlier;
    r = '0;
    earlier = (as < bs) || ((as == bs) && (ans < bns));
    case (op_t'(op))
      OP_ADD: begin
        // The nanosecond sum wraps at 32 bits; the seconds sum is kept exact.
        nsum = ans + bns;
        ssum = {2'b00, as} + {2'b00, bs};
        if (nsum > NSEC_LIMIT) begin
          ssum = ssum + 34'd1;
          nsum = nsum - NSEC_PER_SEC;
        end
        if (ssum > {2'b00, lim}) begin
          r.seconds     = INVALID_MARK;
          r.nanoseconds = INVALID_MARK;
        end else begin
          r.seconds     = ssum[TS_W-1:0];
          r.nanoseconds = (nsum > NSEC_LIMIT) ? NSEC_LIMIT : nsum;
        end
      end
      OP_SUB: begin
        if (earlier) begin
          r.seconds     = INVALID_MARK;
          r.nanoseconds = INVALID_MARK;
        end else if (ans < bns) begin
          r.nanoseconds = ans + NSEC_PER_SEC - bns;
          r.seconds     = as - bs - 32'd1;
        end else begin
          r.nanoseconds = ans - bns;
          r.seconds     = as - bs;
        end
      end
      OP_CMP: begin
        r.is_less  = earlier;
        r.is_equal = (as == bs) && (ans == bns);
      end
      OP_FROM_US: begin
        r.seconds     = tk / USEC_PER_SEC;
        r.nanoseconds = (tk % USEC_PER_SEC) * TS_W'(US_TO_NS);
      end
      OP_FROM_MS: begin
        r.seconds     = tk / MSEC_PER_SEC;
        r.nanoseconds = (tk % MSEC_PER_SEC) * TS_W'(MS_TO_NS);
      end
      OP_SET: begin
        r.seconds     = (as > lim) ? lim : as;
        r.nanoseconds = (ans > NSEC_LIMIT) ? NSEC_LIMIT : ans;
      end
      OP_CHECK: begin
        r.seconds     = as;
        r.nanoseconds = ans;
      end
      default: begin
        r = '0;
      end
    endcase
    // Compare and the unused code leave the range flag clear.
    if (op != OP_CMP && op <= OP_CHECK) begin
      r.in_range = (r.seconds <= lim) && (r.nanoseconds <= NSEC_LIMIT);
    end
    return r;
  endfunction

  function automatic int unsigned field_mismatch(
    input string           field,
    input logic [TS_W-1:0] want,
    input logic [TS_W-1:0] got
  );
    if (got !== want) begin
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    ts_result_t  want;
    int unsigned faults;
    int unsigned pushed;
    int unsigned popped;
    faults = 0;
    pushed = 0;
    popped = 0;
    if (!rst_n) begin
      seconds_limit = SEC_LIMIT_RESET;
      pending_results.delete();
      results_owed   <= 0;
      mismatch_count <= 0;
    end else begin
      if (cfg_we) begin
        seconds_limit = cfg_wdata;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d s %0d ns", $time,
                   out_mon.result_seconds, out_mon.result_nanoseconds);
          faults++;
        end else begin
          want = pending_results.pop_front();
          popped = 1;
          faults += field_mismatch("result_seconds", want.seconds, out_mon.result_seconds);
          faults += field_mismatch("result_nanoseconds", want.nanoseconds,
                                   out_mon.result_nanoseconds);
          faults += field_mismatch("is_less", TS_W'(want.is_less),
                                   TS_W'(out_mon.is_less));
          faults += field_mismatch("is_equal", TS_W'(want.is_equal),
                                   TS_W'(out_mon.is_equal));
          faults += field_mismatch("in_range", TS_W'(want.in_range),
                                   TS_W'(out_mon.in_range));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_results.push_back(timestamp_op_result(in_mon.operation, in_mon.a_seconds,
          in_mon.a_nanoseconds, in_mon.b_seconds, in_mon.b_nanoseconds, in_mon.tick_count,
          seconds_limit));
        pushed = 1;
      end
      results_owed   <= results_owed + pushed - popped;
      mismatch_count <= mismatch_count + faults;
    end
  end

endmodule

[test/timestamp_arithmetic_unit_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Time-stamp arithmetic unit testbench
// Drives directed corner requests and then phases of random requests, one per
// seconds limit setting, random gaps on both channels but in the last phase, one
// long result stall. The checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module timestamp_arithmetic_unit_top_tb;
  import tau_pkg::*;

  localparam int unsigned REQUESTS_PER_PHASE = 212;
  localparam int unsigned HOLD_CYCLES        = 60;
  localparam int unsigned PHASE_COUNT        = 6;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            cfg_we    = 1'b0;
  logic [TS_W-1:0] cfg_wdata = '0;
  int unsigned     results_owed;
  int unsigned     mismatch_count;
  int unsigned     holds_asked = 0;
  logic [TS_W-1:0] limit_now   = SEC_LIMIT_RESET;
  bit              gaps_on     = 1'b1;

  tau_in_if  in_ch ();
  tau_out_if out_ch ();

  timestamp_arithmetic_unit_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tau_result_checker results_watch (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .results_owed   (results_owed),
    .mismatch_count (mismatch_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timestamp_arithmetic_unit_top_tb: done, errors");
    $finish;
  end

  // Result side: random short stalls, plus one long hold when asked for.
  initial begin : result_sink
    int unsigned holds_given;
    holds_given = 0;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_given != holds_asked) begin
        holds_given++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_request(
    input logic [OP_W-1:0] op,
    input logic [TS_W-1:0] as,
    input logic [TS_W-1:0] ans,
    input logic [TS_W-1:0] bs,
    input logic [TS_W-1:0] bns,
    input logic [TS_W-1:0] tk
  );
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.a_seconds     <= as;
    in_ch.a_nanoseconds <= ans;
    in_ch.b_seconds     <= bs;
    in_ch.b_nanoseconds <= bns;
    in_ch.tick_count    <= tk;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  function automatic logic [TS_W-1:0] pick_seconds();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return limit_now - $urandom_range(0, 2);
      3:       return limit_now + 32'd1;
      4:       return $urandom_range(0, 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TS_W-1:0] pick_nanoseconds();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return NSEC_LIMIT;
      2:       return NSEC_PER_SEC;
      3:       return '1;
      4:       return $urandom;
      default: return $urandom_range(0, 999_999_999);
    endcase
  endfunction

  function automatic logic [TS_W-1:0] pick_ticks();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 999);
      1:       return USEC_PER_SEC * $urandom_range(0, 4294);
      2:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly valid time-stamps; b often repeats a, or a's seconds, so that the
  // borrow, equality and near-overflow paths are reached.
  task automatic send_random_request();
    logic [OP_W-1:0] op;
    logic [TS_W-1:0] as;
    logic [TS_W-1:0] ans;
    logic [TS_W-1:0] bs;
    logic [TS_W-1:0] bns;
    op  = OP_W'($urandom_range(OP_ADD, OP_CHECK));
    as  = pick_seconds();
    ans = pick_nanoseconds();
    bs  = pick_seconds();
    bns = pick_nanoseconds();
    case ($urandom_range(0, 5))
      0: begin
        bs  = as;
        bns = ans;
      end
      1: begin
        bs = as;
      end
      2: begin
        bs = $urandom_range(0, 3);
      end
      default: begin
      end
    endcase
    send_request(op, as, ans, bs, bns, pick_ticks());
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  initial begin : stimulus
    logic [TS_W-1:0] limit_plan [PHASE_COUNT];
    int unsigned     phase;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_ADD;
    in_ch.a_seconds     = '0;
    in_ch.a_nanoseconds = '0;
    in_ch.b_seconds     = '0;
    in_ch.b_nanoseconds = '0;
    in_ch.tick_count    = '0;
    limit_plan = '{32'd0, 32'd1000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0, SEC_LIMIT_RESET};
    limit_plan[4] = $urandom;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Corner requests under the reset seconds limit.
    send_request(OP_ADD, 32'd0, 32'd0, 32'd0, 32'd0, $urandom);
    send_request(OP_ADD, 32'd1, 32'd600_000_000, 32'd2, 32'd500_000_000, $urandom);
    send_request(OP_ADD, 32'd7, NSEC_LIMIT, 32'd0, 32'd1, $urandom);
    send_request(OP_ADD, 32'hFFFF_FFFD, 32'd500_000_000, 32'd0, 32'd500_000_000, $urandom);
    send_request(OP_ADD, 32'hFFFF_FFFE, 32'd600_000_000, 32'd0, 32'd400_000_000, $urandom);
    // The nanosecond sum wraps, then one that stays out of range after the carry.
    send_request(OP_ADD, 32'd3, 32'hFFFF_FFFF, 32'd4, 32'd1, $urandom);
    send_request(OP_ADD, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, $urandom);
    send_request(OP_ADD, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, $urandom);
    send_request(OP_SUB, 32'd2, 32'd0, 32'd3, 32'd0, $urandom);
    send_request(OP_SUB, 32'd5, 32'd100, 32'd5, 32'd200, $urandom);
    send_request(OP_SUB, 32'd5, 32'd100, 32'd2, 32'd200, $urandom);
    send_request(OP_SUB, 32'd9, 32'd123, 32'd9, 32'd123, $urandom);
    send_request(OP_SUB, 32'd5, 32'hFFFF_FFFF, 32'd5, 32'd0, $urandom);
    send_request(OP_SUB, 32'hFFFF_FFFF, NSEC_LIMIT, 32'd0, 32'd0, $urandom);
    send_request(OP_CMP, 32'd1, 32'd5, 32'd1, 32'd6, $urandom);
    send_request(OP_CMP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 $urandom);
    send_request(OP_CMP, 32'd2, 32'd0, 32'd1, NSEC_LIMIT, $urandom);
    send_request(OP_FROM_US, $urandom, $urandom, $urandom, $urandom, 32'd0);
    send_request(OP_FROM_US, $urandom, $urandom, $urandom, $urandom, 32'hFFFF_FFFF);
    send_request(OP_FROM_MS, $urandom, $urandom, $urandom, $urandom, 32'hFFFF_FFFF);
    send_request(OP_FROM_MS, $urandom, $urandom, $urandom, $urandom, 32'd999);
    send_request(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom, $urandom, $urandom);
    send_request(OP_SET, 32'd3, NSEC_LIMIT, $urandom, $urandom, $urandom);
    send_request(OP_CHECK, 32'hFFFF_FFFE, NSEC_LIMIT, $urandom, $urandom, $urandom);
    send_request(OP_CHECK, 32'd0, NSEC_PER_SEC, $urandom, $urandom, $urandom);

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_for_drain();
      cfg_we    <= 1'b1;
      cfg_wdata <= limit_plan[phase];
      limit_now = limit_plan[phase];
      @(posedge clk);
      cfg_we <= 1'b0;
      // A long result hold while requests keep coming backs the pipeline up.
      if (phase == 1) begin
        holds_asked <= holds_asked + 1;
      end
      if (phase == PHASE_COUNT - 1) begin
        gaps_on = 1'b0;
      end
      repeat (REQUESTS_PER_PHASE) send_random_request();
    end

    wait_for_drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("timestamp_arithmetic_unit_top_tb: done, clean");
    end else begin
      $display("timestamp_arithmetic_unit_top_tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/tau_pkg.sv
rtl/tau_channels.sv
rtl/timestamp_arithmetic_unit_top.sv
test/tau_result_checker.sv
test/timestamp_arithmetic_unit_top_tb.sv
